>>> rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked property that also holds during reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/rc4_pkg.sv
package rc4_pkg;

	localparam int BYTE_W    = 8;
	localparam int KEY_LEN_W = 9;
	localparam int PERM_N    = 256;

	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_C0   = 9'b000000010,
		ST_C1   = 9'b000000100,
		ST_C2   = 9'b000001000,
		ST_C3   = 9'b000010000,
		ST_K0   = 9'b000100000,
		ST_K1   = 9'b001000000,
		ST_K2   = 9'b010000000,
		ST_K3   = 9'b100000000
	} state_t;

endpackage

>>> rtl/core/rc4_stream_cipher_unit.sv
// data byte: states C0 to C3 after the input transfer, the input stalled until idle
// key byte: the byte that completes the key starts the key schedule,
// 256 swap steps, each through states K0 to K3, on the permutation memory
// reset (arst_n low, asynchronous): permutation reads as identity, indices and
// key count zero, key length 16; key store contents undefined until written
module rc4_stream_cipher_unit #(
	parameter int KEY_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [rc4_pkg::BYTE_W-1:0]    in_byte,
	input  logic                          msg_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rc4_pkg::BYTE_W-1:0]    out_byte,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rc4_pkg::KEY_LEN_W-1:0] cfg_data
);

	localparam int KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam logic [rc4_pkg::KEY_LEN_W-1:0] KEY_DEPTH_L = rc4_pkg::KEY_LEN_W'(KEY_DEPTH);

	rc4_pkg::state_t state_q;

	logic [rc4_pkg::KEY_LEN_W-1:0] key_length_q;
	logic [rc4_pkg::KEY_LEN_W-1:0] count_q;
	logic [rc4_pkg::KEY_LEN_W-1:0] len_q;
	logic [7:0]                    i_q;
	logic [7:0]                    j_q;
	logic [7:0]                    k_q;
	logic [7:0]                    acc_q;
	logic [KIDX_W-1:0]             kidx_q;
	logic [7:0]                    hold_q;
	logic [7:0]                    sj_q;
	logic [7:0]                    byte_q;
	logic                          last_q;
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;

	// permutation memory, entries not yet written read as their own address
	logic [7:0]               perm_q [rc4_pkg::PERM_N];
	logic [rc4_pkg::PERM_N-1:0] perm_valid_q;
	logic [7:0]               prd_data_q;
	logic [7:0]               prd_addr_q;
	logic                     prd_valid_q;
	logic [7:0]               perm_rd;

	logic [7:0] key_mem [KEY_DEPTH];
	logic [7:0] key_rd_q;

	logic       prd_en;
	logic [7:0] prd_addr;
	logic       pwr_en;
	logic [7:0] pwr_addr;
	logic [7:0] pwr_data;
	logic       key_wr_en;
	logic       key_rd_en;

	logic                          in_xfer;
	logic                          out_free;
	logic [rc4_pkg::KEY_LEN_W-1:0] eff_len;
	logic [rc4_pkg::KEY_LEN_W-1:0] count_n;
	logic                          start_ksa;
	logic [7:0]                    j_n;
	logic [7:0]                    acc_n;
	logic [7:0]                    ks_idx;
	logic [7:0]                    ks;
	logic [rc4_pkg::KEY_LEN_W-1:0] kidx_inc;

	assign in_stall  = (state_q != rc4_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign perm_rd  = prd_valid_q ? prd_data_q : prd_addr_q;

	always_comb begin
		if (key_length_q == '0) begin
			eff_len = rc4_pkg::KEY_LEN_W'(1);
		end else if (key_length_q > KEY_DEPTH_L) begin
			eff_len = KEY_DEPTH_L;
		end else begin
			eff_len = key_length_q;
		end
	end

	assign count_n   = count_q + rc4_pkg::KEY_LEN_W'(1);
	assign start_ksa = in_xfer && (cmd == rc4_pkg::CMD_KEY) && (count_n >= eff_len);
	assign key_wr_en = in_xfer && (cmd == rc4_pkg::CMD_KEY) && (count_q < KEY_DEPTH_L);
	assign j_n       = j_q + perm_rd;
	assign acc_n     = acc_q + perm_rd + key_rd_q;
	assign ks_idx    = hold_q + sj_q;
	assign kidx_inc  = rc4_pkg::KEY_LEN_W'(kidx_q) + rc4_pkg::KEY_LEN_W'(1);

	// keystream byte with the swap just made forwarded over the stale read
	always_comb begin
		if (ks_idx == j_q) begin
			ks = hold_q;
		end else if (ks_idx == i_q) begin
			ks = sj_q;
		end else begin
			ks = perm_rd;
		end
	end

	always_comb begin
		prd_en    = 1'b0;
		prd_addr  = i_q;
		pwr_en    = 1'b0;
		pwr_addr  = i_q;
		pwr_data  = sj_q;
		key_rd_en = 1'b0;
		case (state_q)
			rc4_pkg::ST_C0: begin
				prd_en   = 1'b1;
				prd_addr = i_q;
			end
			rc4_pkg::ST_C1: begin
				prd_en   = 1'b1;
				prd_addr = j_n;
			end
			rc4_pkg::ST_C2: begin
				prd_en   = 1'b1;
				prd_addr = hold_q + perm_rd;
				pwr_en   = 1'b1;
				pwr_addr = i_q;
				pwr_data = perm_rd;
			end
			rc4_pkg::ST_C3: begin
				pwr_en   = 1'b1;
				pwr_addr = j_q;
				pwr_data = hold_q;
			end
			rc4_pkg::ST_K0: begin
				prd_en    = 1'b1;
				prd_addr  = k_q;
				key_rd_en = 1'b1;
			end
			rc4_pkg::ST_K1: begin
				prd_en   = 1'b1;
				prd_addr = acc_n;
			end
			rc4_pkg::ST_K2: begin
				pwr_en   = 1'b1;
				pwr_addr = k_q;
				pwr_data = perm_rd;
			end
			rc4_pkg::ST_K3: begin
				pwr_en   = 1'b1;
				pwr_addr = acc_q;
				pwr_data = hold_q;
			end
			default: begin
				prd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pwr_en) begin
			perm_q[pwr_addr] <= pwr_data;
		end
		if (prd_en) begin
			prd_data_q <= perm_q[prd_addr];
			prd_addr_q <= prd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (key_wr_en) begin
			key_mem[count_q[KIDX_W-1:0]] <= in_byte;
		end
		if (key_rd_en) begin
			key_rd_q <= key_mem[kidx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_valid_q <= '0;
			prd_valid_q  <= 1'b0;
		end else begin
			if (prd_en) begin
				prd_valid_q <= perm_valid_q[prd_addr];
			end
			// the key schedule starts from identity: drop every written entry
			if (start_ksa) begin
				perm_valid_q <= '0;
			end else if (pwr_en) begin
				perm_valid_q[pwr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_q <= in_byte;
			last_q <= msg_last;
		end
		case (state_q)
			rc4_pkg::ST_C1: begin
				hold_q <= perm_rd;
			end
			rc4_pkg::ST_C2: begin
				sj_q <= perm_rd;
			end
			rc4_pkg::ST_C3: begin
				if (out_free) begin
					out_byte_q <= byte_q ^ ks;
				end
			end
			rc4_pkg::ST_K1: begin
				hold_q <= perm_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rc4_pkg::ST_IDLE;
			key_length_q <= rc4_pkg::KEY_LEN_RESET;
			count_q      <= '0;
			len_q        <= rc4_pkg::KEY_LEN_RESET;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			acc_q        <= '0;
			kidx_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				key_length_q <= cfg_data;
			end
			// the last data cycle sets the valid flag itself
			if (out_valid_q && !out_stall && (state_q != rc4_pkg::ST_C3)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rc4_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (cmd == rc4_pkg::CMD_DATA) begin
							i_q     <= i_q + 8'd1;
							state_q <= rc4_pkg::ST_C0;
						end else begin
							count_q <= count_n;
							if (start_ksa) begin
								len_q   <= eff_len;
								acc_q   <= '0;
								k_q     <= '0;
								kidx_q  <= '0;
								state_q <= rc4_pkg::ST_K0;
							end
						end
					end
				end
				rc4_pkg::ST_C0: begin
					state_q <= rc4_pkg::ST_C1;
				end
				rc4_pkg::ST_C1: begin
					j_q     <= j_n;
					state_q <= rc4_pkg::ST_C2;
				end
				rc4_pkg::ST_C2: begin
					state_q <= rc4_pkg::ST_C3;
				end
				rc4_pkg::ST_C3: begin
					// hold here until the output register can take the byte
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (last_q) begin
							i_q <= '0;
							j_q <= '0;
						end
						state_q <= rc4_pkg::ST_IDLE;
					end
				end
				rc4_pkg::ST_K0: begin
					state_q <= rc4_pkg::ST_K1;
				end
				rc4_pkg::ST_K1: begin
					acc_q   <= acc_n;
					state_q <= rc4_pkg::ST_K2;
				end
				rc4_pkg::ST_K2: begin
					state_q <= rc4_pkg::ST_K3;
				end
				rc4_pkg::ST_K3: begin
					k_q <= k_q + 8'd1;
					// key index runs cyclically over the stored key length
					if (kidx_inc == len_q) begin
						kidx_q <= '0;
					end else begin
						kidx_q <= kidx_inc[KIDX_W-1:0];
					end
					if (k_q == 8'hFF) begin
						i_q     <= '0;
						j_q     <= '0;
						count_q <= '0;
						state_q <= rc4_pkg::ST_IDLE;
					end else begin
						state_q <= rc4_pkg::ST_K0;
					end
				end
				default: begin
					state_q <= rc4_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/rc4_checker.sv
`include "assert_macros.svh"

module rc4_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       cmd,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [rc4_pkg::BYTE_W-1:0] out_byte
);

	// a waiting result keeps its byte until the transfer
	`ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_byte), "stalled result changed")

	// a data byte keeps the input side busy through states C0 to C2 of its swap sequence
	`ASSERT_CLK(a_data_busy, in_valid && !in_stall && cmd == rc4_pkg::CMD_DATA |=> in_stall ##1 in_stall ##1 in_stall, "data byte finished too early")

	// a new result only appears at the end of a busy period
	`ASSERT_CLK(a_out_from_work, $rose(out_valid) |-> $past(in_stall), "result without work")

endmodule

bind rc4_stream_cipher_unit rc4_checker u_rc4_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int ITEM_TARGET   = 850;
	// wait long enough for the whole key schedule, plus margin
	localparam int SCHEDULE_WAIT = 1100;

	class rc4_scoreboard;
		bit [7:0] perm [256];
		bit [7:0] key_bytes [256];
		bit [7:0] idx_i;
		bit [7:0] idx_j;
		bit [8:0] key_count;
		bit [8:0] key_length;
		bit [7:0] expected_bytes [$];
		int errors;

		function new();
			for (int k = 0; k < 256; k++) begin
				perm[k] = k[7:0];
				key_bytes[k] = '0;
			end
			idx_i = '0;
			idx_j = '0;
			key_count = '0;
			key_length = rc4_pkg::KEY_LEN_RESET;
			errors = 0;
		endfunction

		function int unsigned used_length();
			if (key_length == 0)
				return 1;
			if (key_length > 256)
				return 256;
			return 32'(key_length);
		endfunction

		function int unsigned bytes_to_key();
			int unsigned len;
			len = used_length();
			return (32'(key_count) >= len) ? 1 : len - 32'(key_count);
		endfunction

		function void set_key_length(bit [8:0] v);
			key_length = v;
		endfunction

		function void swap_perm(bit [7:0] a, bit [7:0] b);
			bit [7:0] t;
			t = perm[a];
			perm[a] = perm[b];
			perm[b] = t;
		endfunction

		function void run_key_schedule(int unsigned len);
			bit [7:0] acc;
			acc = '0;
			for (int k = 0; k < 256; k++)
				perm[k] = k[7:0];
			for (int k = 0; k < 256; k++) begin
				acc = acc + perm[k] + key_bytes[8'(k % len)];
				swap_perm(k[7:0], acc);
			end
			idx_i = '0;
			idx_j = '0;
			key_count = '0;
		endfunction

		function void note_input(logic c, logic [7:0] b, logic last);
			int unsigned len;
			bit [7:0] ks_index;
			if (c == rc4_pkg::CMD_KEY) begin
				len = used_length();
				if (key_count < 256)
					key_bytes[key_count[7:0]] = b;
				key_count = key_count + 1;
				if (32'(key_count) >= len)
					run_key_schedule(len);
			end else begin
				idx_i = idx_i + 1;
				idx_j = idx_j + perm[idx_i];
				swap_perm(idx_i, idx_j);
				ks_index = perm[idx_i] + perm[idx_j];
				expected_bytes.push_back(b ^ perm[ks_index]);
				if (last) begin
					idx_i = '0;
					idx_j = '0;
				end
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(logic [7:0] b);
			bit [7:0] want;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected out_byte %h", b));
			end else begin
				want = expected_bytes.pop_front();
				if (b !== want)
					report($sformatf("out_byte got %h expected %h", b, want));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = rc4_pkg::CMD_KEY;
	logic [rc4_pkg::BYTE_W-1:0] in_byte = '0;
	logic msg_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [rc4_pkg::BYTE_W-1:0] out_byte;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rc4_pkg::KEY_LEN_W-1:0] cfg_data = '0;

	rc4_scoreboard sb = new();

	int unsigned burst_left = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;

	int unsigned stall_mode = 0;
	int unsigned mode_left = 0;
	int unsigned run_left = 0;
	logic run_stall = 1'b0;

	rc4_stream_cipher_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.in_byte(in_byte),
		.msg_last(msg_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// output side: check each transfer, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_byte);
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(50, 300);
		end
		mode_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 10);
					run_stall = ~run_stall;
				end
				run_left--;
				out_stall <= run_stall;
			end
		endcase
	end

	function automatic logic [7:0] random_byte();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	task send_item(input logic c, input logic [7:0] b, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= c;
		in_byte <= b;
		msg_last <= last;
		do @(posedge clk); while (in_stall);
		sb.note_input(c, b, last);
		items_sent++;
	endtask

	task wait_for_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// a key byte gives no result, so a schedule may still be running after the drain
	task write_key_length(input logic [rc4_pkg::KEY_LEN_W-1:0] v);
		wait_for_results();
		repeat (SCHEDULE_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_key_length(v);
	endtask

	task run_phase(input int num);
		int unsigned pick;
		int unsigned n;
		int unsigned msgs;
		int unsigned len;
		logic [rc4_pkg::KEY_LEN_W-1:0] v;
		pick = $urandom_range(0, 99);
		if (num == 0)
			v = 9'd511;
		else if (num == 1)
			v = 9'd256;
		else if (pick < 60)
			v = rc4_pkg::KEY_LEN_W'($urandom_range(1, 8));
		else if (pick < 78)
			v = rc4_pkg::KEY_LEN_W'($urandom_range(9, 32));
		else if (pick < 88)
			v = '0;
		else if (pick < 95)
			v = rc4_pkg::KEY_LEN_W'($urandom_range(33, 64));
		else
			v = 9'd1;
		if (num < 2 || $urandom_range(0, 3) != 0)
			write_key_length(v);
		else if ($urandom_range(0, 2) == 0)
			wait_for_results();
		if (num == 1 || (num > 1 && $urandom_range(0, 4) == 0)) begin
			// noise: stray keys, stray flags, data on a half-built key
			n = $urandom_range(4, 16);
			repeat (n)
				send_item(($urandom_range(0, 3) == 0) ? rc4_pkg::CMD_KEY : rc4_pkg::CMD_DATA,
					random_byte(), 1'($urandom_range(0, 1)));
		end else begin
			n = sb.bytes_to_key();
			repeat (n)
				send_item(rc4_pkg::CMD_KEY, random_byte(), $urandom_range(0, 4) == 0);
			msgs = $urandom_range(1, 4);
			repeat (msgs) begin
				len = $urandom_range(1, 16);
				for (int k = 1; k <= len; k++)
					send_item(rc4_pkg::CMD_DATA, random_byte(), k == len);
			end
		end
	endtask

	initial begin
		int phase_num;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// data on the reset permutation, before any key
		send_item(rc4_pkg::CMD_DATA, 8'h00, 1'b0);
		send_item(rc4_pkg::CMD_DATA, 8'hFF, 1'b1);
		// partial key, last flag on a key byte is ignored
		send_item(rc4_pkg::CMD_KEY, 8'h5A, 1'b1);
		send_item(rc4_pkg::CMD_KEY, 8'h00, 1'b0);
		send_item(rc4_pkg::CMD_KEY, 8'hFF, 1'b0);
		send_item(rc4_pkg::CMD_DATA, 8'h3C, 1'b1);
		// length lowered below stored count: next key byte schedules at once
		write_key_length(9'd2);
		send_item(rc4_pkg::CMD_KEY, 8'h81, 1'b0);
		send_item(rc4_pkg::CMD_DATA, 8'h00, 1'b0);
		send_item(rc4_pkg::CMD_DATA, 8'hFF, 1'b0);
		send_item(rc4_pkg::CMD_DATA, 8'hA5, 1'b1);
		send_item(rc4_pkg::CMD_DATA, 8'h96, 1'b0);
		// zero length acts as one
		write_key_length(9'd0);
		send_item(rc4_pkg::CMD_KEY, 8'hFF, 1'b0);
		send_item(rc4_pkg::CMD_DATA, 8'h55, 1'b0);
		send_item(rc4_pkg::CMD_DATA, 8'hAA, 1'b1);

		phase_num = 0;
		while (items_sent < ITEM_TARGET) begin
			run_phase(phase_num);
			phase_num++;
		end

		wait_for_results();
		repeat (SCHEDULE_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/rc4_pkg.sv
rtl/core/rc4_stream_cipher_unit.sv
rtl/core/rc4_checker.sv
tb/tb_top.sv
